/* sv/mmt_pkg.sv */
// shared types and constants for the minimum merge total cost block
// no dependencies; imported by mmt_heap and min_merge_total_cost
`timescale 1ns / 1ps
`default_nettype none

package mmt_pkg;

  localparam int LEN_W  = 16;
  localparam int COST_W = 32;
  localparam logic [COST_W-1:0] COST_MAX = '1;

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_MERGE = 2'd1,
    OP_CLEAR = 2'd2
  } heap_op_t;

  typedef struct packed {
    logic     valid;
    heap_op_t op;
  } heap_cmd_t;

  typedef struct packed {
    logic done;
    logic full;
    logic multi;
  } heap_stat_t;

endpackage

`default_nettype wire

/* sv/mmt_heap.sv */
// min-heap engine: one synchronous memory, insert by sift-up, merge step by pop plus
// replace-root with sift-down; depends on mmt_pkg
`timescale 1ns / 1ps
`default_nettype none

module mmt_heap import mmt_pkg::*; #(
  parameter int MAX_ITEMS = 256,
  parameter int ENTRY_W   = 24
) (
  input  logic               clk,
  input  logic               rst,
  input  heap_cmd_t          cmd,
  input  logic [ENTRY_W-1:0] push_value,
  output heap_stat_t         stat,
  output logic [ENTRY_W-1:0] merge_sum
);

  localparam int IW = $clog2(MAX_ITEMS);
  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam int XW = CW + 1;

  typedef enum logic [5:0] {
    H_IDLE   = 6'b000001,
    H_UP     = 6'b000010,
    H_UP_FIN = 6'b000100,
    H_LOAD   = 6'b001000,
    H_DOWN   = 6'b010000,
    H_SUM    = 6'b100000
  } heap_state_t;

  heap_state_t state;

  logic [ENTRY_W-1:0] mem [MAX_ITEMS];
  logic [ENTRY_W-1:0] rd_a, rd_b;

  logic [CW-1:0]      count;
  logic [IW-1:0]      idx, par;
  logic [ENTRY_W-1:0] x, taken, root_val;
  logic               second;

  logic               we;
  logic [IW-1:0]      waddr, ra, rb;
  logic [ENTRY_W-1:0] wdata;

  logic [XW-1:0]      lchild, rchild, n_ext, gchild;
  logic               has_l, has_r, pick_r, go_down, up_stop;
  logic [ENTRY_W-1:0] child_val;
  logic [IW-1:0]      child_idx, grand_par, push_par;

  // child and parent arithmetic
  always_comb begin
    n_ext     = XW'(count);
    lchild    = (XW'(idx) << 1) + XW'(1);
    rchild    = lchild + XW'(1);
    has_l     = lchild < n_ext;
    has_r     = rchild < n_ext;
    pick_r    = has_r && (rd_b < rd_a);
    child_val = pick_r ? rd_b : rd_a;
    child_idx = pick_r ? IW'(rchild) : IW'(lchild);
    go_down   = has_l && (child_val < x);
    gchild    = (XW'(child_idx) << 1) + XW'(1);
    grand_par = IW'((XW'(par) - XW'(1)) >> 1);
    push_par  = IW'((XW'(count) - XW'(1)) >> 1);
    up_stop   = rd_a <= x;
  end

  // memory port control
  always_comb begin
    we    = 1'b0;
    waddr = idx;
    wdata = x;
    ra    = '0;
    rb    = '0;
    unique case (state)
      H_IDLE: begin
        if (cmd.op == OP_MERGE) begin
          rb = IW'(n_ext - XW'(1));
        end else begin
          ra = push_par;
        end
      end
      H_UP: begin
        we = 1'b1;
        if (!up_stop) begin
          wdata = rd_a;
        end
        ra = grand_par;
      end
      H_UP_FIN: begin
        we = 1'b1;
      end
      H_LOAD, H_SUM: begin
        ra = IW'(1);
        rb = IW'(2);
      end
      H_DOWN: begin
        we = 1'b1;
        if (go_down) begin
          wdata = child_val;
        end
        ra = IW'(gchild);
        rb = IW'(gchild + XW'(1));
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_a <= mem[ra];
    rd_b <= mem[rb];
  end

  always_ff @(posedge clk) begin
    if (we && waddr == '0) begin
      root_val <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= H_IDLE;
      count <= '0;
    end else begin
      unique case (state)
        H_IDLE: begin
          if (cmd.valid) begin
            unique case (cmd.op)
              OP_PUSH: begin
                x     <= push_value;
                idx   <= IW'(count);
                count <= count + CW'(1);
                if (count == '0) begin
                  state <= H_UP_FIN;
                end else begin
                  par   <= push_par;
                  state <= H_UP;
                end
              end
              OP_MERGE: begin
                state <= H_LOAD;
              end
              OP_CLEAR: begin
                count <= '0;
              end
              default: begin
                state <= H_IDLE;
              end
            endcase
          end
        end
        H_UP: begin
          if (up_stop) begin
            state <= H_IDLE;
          end else begin
            idx <= par;
            if (par == '0) begin
              state <= H_UP_FIN;
            end else begin
              par <= grand_par;
            end
          end
        end
        H_UP_FIN: begin
          state <= H_IDLE;
        end
        H_LOAD: begin
          // root leaves, last entry moves into the hole at the root
          taken  <= rd_a;
          x      <= rd_b;
          count  <= count - CW'(1);
          idx    <= '0;
          second <= 1'b0;
          state  <= H_DOWN;
        end
        H_DOWN: begin
          if (go_down) begin
            idx <= child_idx;
          end else if (second) begin
            state <= H_IDLE;
          end else begin
            state <= H_SUM;
          end
        end
        H_SUM: begin
          // replace the new minimum with the pair sum
          x         <= taken + root_val;
          merge_sum <= taken + root_val;
          idx       <= '0;
          second    <= 1'b1;
          state     <= H_DOWN;
        end
        default: begin
          state <= H_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    stat.done  = (state == H_UP && up_stop) || (state == H_UP_FIN) ||
                 (state == H_DOWN && !go_down && second);
    stat.full  = count == CW'(MAX_ITEMS);
    stat.multi = count > CW'(1);
  end

endmodule

`default_nettype wire

/* sv/min_merge_total_cost.sv */
// Minimum merge total cost. Each accepted transaction inserts one length into a min-heap held
// in a single synchronous memory; the transaction marked is_last starts repeated merging of the
// two smallest entries and yields one result with the saturating sum of all merge sums and a
// flag for lengths dropped when the heap was full. An insert makes one memory read per heap
// level through the sift-up loop. Each merge step makes two sift-down passes of one level per
// cycle; a set of n items ends with roughly (n-1) merge steps before the result. Input is
// stalled while the heap is busy; a finished result waits in the output register. No clearing
// pass after reset.
// depends on mmt_pkg and mmt_heap
`timescale 1ns / 1ps
`default_nettype none

module min_merge_total_cost import mmt_pkg::*; #(
  parameter int MAX_ITEMS = 256,
  parameter int LEN_BITS  = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [LEN_W-1:0]  length_value,
  input  logic              is_last,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [COST_W-1:0] total_cost,
  output logic              overflowed
);

  localparam int ENTRY_W = LEN_BITS + $clog2(MAX_ITEMS);
  localparam int SUM_W   = ((ENTRY_W > COST_W) ? ENTRY_W : COST_W) + 1;
  localparam logic [ENTRY_W-1:0] LEN_MASK = ENTRY_W'((64'(1) << LEN_BITS) - 64'(1));

  typedef enum logic [4:0] {
    T_IDLE  = 5'b00001,
    T_PUSH  = 5'b00010,
    T_CHECK = 5'b00100,
    T_MERGE = 5'b01000,
    T_EMIT  = 5'b10000
  } ctrl_state_t;

  ctrl_state_t        state;
  heap_cmd_t          cmd;
  heap_stat_t         hstat;
  logic [ENTRY_W-1:0] push_value, merge_sum;
  logic [COST_W-1:0]  cost, cost_next;
  logic [SUM_W-1:0]   cost_sum;
  logic               drop, pend_last, accept, out_free;

  assign in_stall   = state != T_IDLE;
  assign accept     = in_valid && !in_stall;
  assign out_free   = !out_valid || !out_stall;
  assign push_value = ENTRY_W'(length_value) & LEN_MASK;

  always_comb begin
    cost_sum  = SUM_W'(cost) + SUM_W'(merge_sum);
    cost_next = (cost_sum[SUM_W-1:COST_W] != '0) ? COST_MAX : cost_sum[COST_W-1:0];
  end

  always_comb begin
    cmd.valid = 1'b0;
    cmd.op    = OP_PUSH;
    unique case (state)
      T_IDLE: begin
        cmd.valid = accept && !hstat.full;
      end
      T_CHECK: begin
        cmd.valid = hstat.multi;
        cmd.op    = OP_MERGE;
      end
      T_EMIT: begin
        cmd.valid = out_free;
        cmd.op    = OP_CLEAR;
      end
      default: begin
        cmd.valid = 1'b0;
      end
    endcase
  end

  mmt_heap #(
    .MAX_ITEMS(MAX_ITEMS),
    .ENTRY_W  (ENTRY_W)
  ) u_heap (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .push_value(push_value),
    .stat      (hstat),
    .merge_sum (merge_sum)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= T_IDLE;
      drop      <= 1'b0;
      cost      <= '0;
      pend_last <= 1'b0;
    end else begin
      unique case (state)
        T_IDLE: begin
          if (accept) begin
            pend_last <= is_last;
            if (!hstat.full) begin
              state <= T_PUSH;
            end else begin
              // heap full: length is dropped, merging still runs on a last item
              drop <= 1'b1;
              if (is_last) begin
                state <= T_CHECK;
              end
            end
          end
        end
        T_PUSH: begin
          if (hstat.done) begin
            state <= pend_last ? T_CHECK : T_IDLE;
          end
        end
        T_CHECK: begin
          state <= hstat.multi ? T_MERGE : T_EMIT;
        end
        T_MERGE: begin
          if (hstat.done) begin
            cost  <= cost_next;
            state <= T_CHECK;
          end
        end
        T_EMIT: begin
          if (out_free) begin
            cost  <= '0;
            drop  <= 1'b0;
            state <= T_IDLE;
          end
        end
        default: begin
          state <= T_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == T_EMIT && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == T_EMIT && out_free) begin
      total_cost <= cost;
      overflowed <= drop;
    end
  end

endmodule

`default_nettype wire

/* sv/mmt_check.sv */
// port-level checks for min_merge_total_cost, attached by bind
// depends on the port names of min_merge_total_cost
`timescale 1ns / 1ps
`default_nettype none

module mmt_check (
  input wire        clk,
  input wire        rst,
  input wire        in_valid,
  input wire        in_stall,
  input wire        is_last,
  input wire        out_valid,
  input wire        out_stall,
  input wire [31:0] total_cost,
  input wire        overflowed
);

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(total_cost) && $stable(overflowed))
    else $error("result changed while stalled");

  // the closing transaction of a set always keeps the block busy for merging
  a_last_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && is_last |=> in_stall)
    else $error("input not stalled after last transaction");

  // a result only appears while input is held off
  a_emit_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result loaded while input open");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind min_merge_total_cost mmt_check u_mmt_check (.*);

`default_nettype wire

/* verif/min_merge_total_cost_test.sv */
// self-checking test for min_merge_total_cost: sets of lengths go in, each set's total cost and drop flag come out
// needs mmt_pkg and the min_merge_total_cost rtl; nothing else
`timescale 1ns / 1ps

module min_merge_total_cost_test;
  import mmt_pkg::*;

  localparam int HEAP_DEPTH     = 256;
  localparam int ITEM_TARGET    = 1500;
  localparam int HOLD_AT        = 700;
  localparam int HOLD_CYCLES    = 3000;
  localparam int QUIET_FROM     = 1000;
  localparam int QUIET_TO       = 1250;
  localparam int IDLE_PCT       = 23;
  localparam int WATCHDOG_LIMIT = 100000;
  localparam int DRAIN_CYCLES   = 100;

  typedef struct {
    logic [LEN_W-1:0] len;
    logic             last;
    bit               wait_drain;
  } length_item_t;

  typedef struct {
    logic [COST_W-1:0] cost;
    logic              dropped;
  } merge_result_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [LEN_W-1:0]  length_value = '0;
  logic              is_last = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [COST_W-1:0] total_cost;
  logic              overflowed;

  length_item_t      pending_items[$];
  merge_result_t     expected_results[$];
  longint unsigned   heap_lengths[$];
  bit                drop_seen;
  int                sent_count;
  int                error_count;
  int                stuck_cycles;
  int                hold_left;
  bit                hold_done;
  logic              quiet;

  assign quiet = sent_count >= QUIET_FROM && sent_count < QUIET_TO;

  min_merge_total_cost #(
    .MAX_ITEMS(HEAP_DEPTH),
    .LEN_BITS (LEN_W)
  ) uut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .length_value(length_value),
    .is_last     (is_last),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .total_cost  (total_cost),
    .overflowed  (overflowed)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // store one length; on the final one merge the two smallest until one is left
  task automatic take_length(input logic [LEN_W-1:0] len, input logic last);
    longint unsigned a;
    longint unsigned b;
    longint unsigned cost;
    merge_result_t   res;
    if (heap_lengths.size() < HEAP_DEPTH) heap_lengths.insert(heap_lengths.size(), len);
    else drop_seen = 1'b1;
    if (last) begin
      cost = 0;
      while (heap_lengths.size() > 1) begin
        heap_lengths.sort();
        a = heap_lengths.pop_front();
        b = heap_lengths.pop_front();
        heap_lengths.insert(heap_lengths.size(), a + b);
        cost += a + b;
        if (cost > COST_MAX) cost = COST_MAX;
      end
      res.cost = cost[COST_W-1:0];
      res.dropped = drop_seen;
      expected_results.insert(expected_results.size(), res);
      heap_lengths.delete();
      drop_seen = 1'b0;
    end
  endtask

  function automatic logic [LEN_W-1:0] random_length();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      2: return LEN_W'($urandom_range(15));
      default: return LEN_W'($urandom());
    endcase
  endfunction

  task automatic add_item(input logic [LEN_W-1:0] len, input logic last);
    pending_items.insert(pending_items.size(), '{len: len, last: last, wait_drain: 1'b0});
  endtask

  task automatic add_set(input int n, input bit drain);
    for (int k = 0; k < n; k++) begin
      pending_items.insert(pending_items.size(), '{len: random_length(), last: k == n - 1,
                                                   wait_drain: drain && k == 0});
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      sent_count <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        take_length(length_value, is_last);
        sent_count <= sent_count + 1;
      end
      if (!in_valid || !in_stall) begin
        if (pending_items.size() != 0
            && !(pending_items[0].wait_drain && expected_results.size() != 0)
            && (quiet || $urandom_range(99) >= IDLE_PCT)) begin
          length_value <= pending_items[0].len;
          is_last <= pending_items[0].last;
          in_valid <= 1'b1;
          pending_items.delete(0);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result side stall, with one long hold-off so the input backs up behind a held result
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && sent_count >= HOLD_AT) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !quiet && $urandom_range(99) < IDLE_PCT;
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $error("unexpected transaction: total_cost %0d overflowed %0b", total_cost, overflowed);
        error_count++;
      end else begin
        if (total_cost !== expected_results[0].cost) begin
          $error("total_cost expected %0d actual %0d", expected_results[0].cost, total_cost);
          error_count++;
        end
        if (overflowed !== expected_results[0].dropped) begin
          $error("overflowed expected %0b actual %0b", expected_results[0].dropped, overflowed);
          error_count++;
        end
        expected_results.delete(0);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    int roll;
    int n;
    // lone items, extreme values, ties and alternating bit patterns
    add_item(16'h0000, 1'b1);
    add_item(16'hFFFF, 1'b1);
    add_item(16'h0000, 1'b0);
    add_item(16'hFFFF, 1'b1);
    add_item(16'hFFFF, 1'b0);
    add_item(16'hFFFF, 1'b1);
    for (int k = 1; k <= 5; k++) add_item(LEN_W'(k), k == 5);
    for (int k = 0; k < 3; k++) add_item(16'h0000, k == 2);
    for (int k = 0; k < 4; k++) add_item(16'd7, k == 3);
    add_item(16'hAAAA, 1'b0);
    add_item(16'h5555, 1'b1);
    // exactly full, then two past full so the final length is dropped as well
    add_set(HEAP_DEPTH, 1'b1);
    add_set(HEAP_DEPTH + 2, 1'b1);
    while (pending_items.size() < ITEM_TARGET) begin
      roll = $urandom_range(99);
      if (roll < 2) n = $urandom_range(300, 240);
      else if (roll < 10) n = $urandom_range(40, 13);
      else n = $urandom_range(12, 1);
      if (n > ITEM_TARGET - pending_items.size()) n = ITEM_TARGET - pending_items.size();
      add_set(n, $urandom_range(29) == 0);
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    while (pending_items.size() != 0 || in_valid) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/mmt_pkg.sv
sv/mmt_heap.sv
sv/min_merge_total_cost.sv
sv/mmt_check.sv
verif/min_merge_total_cost_test.sv
